// ===== hw/rtl/mcas_pkg.sv =====
// Shared types and constants of the min-cost assignment solver.
`default_nettype none
package mcas_pkg;

    localparam int MAX_N     = 16;
    localparam int IDX_W     = 5;
    localparam int ROW_W     = 4;
    localparam int COST_BITS = 16;
    localparam int POT_W     = 24;
    localparam int CUR_W     = 26;
    localparam int TOTAL_W   = 20;
    localparam int ADDR_W    = 8;
    localparam int DEPTH     = MAX_N * MAX_N;

    localparam logic signed [POT_W-1:0] SLACK_INF = 24'sh7FFFFF;

    typedef struct packed {
        logic [ROW_W-1:0]            entry_row;
        logic [ROW_W-1:0]            entry_col;
        logic signed [COST_BITS-1:0] entry_cost;
        logic                        last_entry;
    } entry_t;

    typedef struct packed {
        logic [ROW_W-1:0]            result_row;
        logic [ROW_W-1:0]            assigned_col;
        logic signed [COST_BITS-1:0] pair_cost;
        logic signed [TOTAL_W-1:0]   running_total;
        logic                        last_result;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SOLVE_INIT,
        ST_ROW_INIT,
        ST_STEP,
        ST_READ,
        ST_COMPARE,
        ST_UPDATE,
        ST_AUGMENT,
        ST_ASSIGN,
        ST_OUT_READ,
        ST_OUT_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SOLVE_INIT,
        OP_ROW_INIT,
        OP_STEP,
        OP_READ,
        OP_COMPARE,
        OP_UPDATE,
        OP_AUGMENT,
        OP_ASSIGN,
        OP_OUT_READ,
        OP_OUT_EMIT
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic step_again;
        logic aug_last;
        logic rows_done;
        logic out_done;
    } stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mcas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mcas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mcas_ctrl.sv =====
// Controller state machine that sequences loading, solving and result output.
`default_nettype none
module mcas_ctrl
    import mcas_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire logic  last_entry,
    input  wire stat_t stat,
    output cmd_t       cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.op     = OP_NONE;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
                if (start && last_entry)
                begin
                    state_next = ST_SOLVE_INIT;
                end
            end
            ST_SOLVE_INIT:
            begin
                cmd.op     = OP_SOLVE_INIT;
                state_next = ST_ROW_INIT;
            end
            ST_ROW_INIT:
            begin
                cmd.op     = OP_ROW_INIT;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.op     = OP_STEP;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.op     = OP_READ;
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                cmd.op     = OP_COMPARE;
                state_next = stat.scan_done ? ST_UPDATE : ST_READ;
            end
            ST_UPDATE:
            begin
                cmd.op = OP_UPDATE;
                if (stat.scan_done)
                begin
                    state_next = stat.step_again ? ST_STEP : ST_AUGMENT;
                end
            end
            ST_AUGMENT:
            begin
                cmd.op = OP_AUGMENT;
                if (stat.aug_last)
                begin
                    state_next = stat.rows_done ? ST_ASSIGN : ST_ROW_INIT;
                end
            end
            ST_ASSIGN:
            begin
                cmd.op = OP_ASSIGN;
                if (stat.scan_done)
                begin
                    state_next = ST_OUT_READ;
                end
            end
            ST_OUT_READ:
            begin
                cmd.op     = OP_OUT_READ;
                state_next = ST_OUT_EMIT;
            end
            ST_OUT_EMIT:
            begin
                cmd.op     = OP_OUT_EMIT;
                state_next = stat.out_done ? ST_IDLE : ST_OUT_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mcas_dp.sv =====
// Datapath: cost memory, potentials, slack, matching and result registers.
`default_nettype none
module mcas_dp
    import mcas_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [4:0]   cfg_data,
    input  wire entry_t       entry,
    input  wire cmd_t         cmd,
    output stat_t             stat,
    output logic              result_valid,
    output result_t           result
);

    logic [4:0]              size_reg;
    logic [IDX_W-1:0]        n;
    logic signed [POT_W-1:0] u_reg  [MAX_N+1];
    logic signed [POT_W-1:0] v_reg  [MAX_N+1];
    logic signed [POT_W-1:0] ms_reg [MAX_N+1];
    logic [IDX_W-1:0]        cm_reg [MAX_N+1];
    logic [IDX_W-1:0]        bk_reg [MAX_N+1];
    logic [MAX_N:0]          used_reg;
    logic [ROW_W-1:0]        asg_reg [MAX_N];
    logic [IDX_W-1:0]        i_reg, j_reg, j0_reg, j1_reg, guard_reg, i0_reg;
    logic signed [POT_W-1:0] ui0_reg, delta_reg;
    logic [ROW_W-1:0]        r_reg;
    logic signed [TOTAL_W-1:0] total_reg;
    result_t                 res_reg;
    logic                    res_valid_reg;

    logic                    ram_we;
    logic [ADDR_W-1:0]       waddr, raddr;
    logic [COST_BITS-1:0]    rdata;
    logic signed [COST_BITS-1:0] cost;
    logic [IDX_W-1:0]        jm1, i0m1, jb, p;
    logic                    i0_ok;
    logic signed [CUR_W-1:0] cur_raw, cur_w;
    logic signed [POT_W-1:0] cur, new_ms;
    logic signed [TOTAL_W-1:0] total_sum;

    assign n = (size_reg == 5'd0) ? 5'd1 :
               (size_reg > 5'(MAX_N)) ? 5'(MAX_N) : size_reg;

    assign ram_we = cmd.load && ({1'b0, entry.entry_row} < n) && ({1'b0, entry.entry_col} < n);
    assign waddr  = {entry.entry_row, entry.entry_col};
    assign jm1    = j_reg - 5'd1;
    assign i0m1   = i0_reg - 5'd1;
    assign raddr  = (cmd.op == OP_OUT_READ) ? {r_reg, asg_reg[r_reg]}
                                            : {i0m1[3:0], jm1[3:0]};

    mcas_ram #(.WIDTH(COST_BITS), .DEPTH(DEPTH)) u_cost_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (entry.entry_cost),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cost    = $signed(rdata);
    assign i0_ok   = (i0_reg >= 5'd1) && (i0_reg <= n);
    assign cur_raw = CUR_W'(cost) - CUR_W'(ui0_reg) - CUR_W'(v_reg[j_reg]);
    assign cur_w   = i0_ok ? cur_raw : '0;
    assign cur     = (cur_w > CUR_W'(SLACK_INF)) ? SLACK_INF : cur_w[POT_W-1:0];
    assign new_ms  = (cur < ms_reg[j_reg]) ? cur : ms_reg[j_reg];
    assign jb      = (bk_reg[j0_reg] > 5'(MAX_N)) ? 5'd0 : bk_reg[j0_reg];
    assign p       = cm_reg[j_reg] - 5'd1;
    assign total_sum = total_reg + TOTAL_W'(cost);

    assign stat.scan_done  = (j_reg == n);
    assign stat.step_again = (cm_reg[j1_reg] != 5'd0) && (guard_reg <= n);
    assign stat.aug_last   = (jb == 5'd0) || (guard_reg > n);
    assign stat.rows_done  = (i_reg == n);
    assign stat.out_done   = ({1'b0, r_reg} == n - 5'd1);

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= 5'd1;
            used_reg      <= '0;
            res_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            j0_reg        <= '0;
            j1_reg        <= '0;
            guard_reg     <= '0;
            i0_reg        <= '0;
            r_reg         <= '0;
            ui0_reg       <= '0;
            delta_reg     <= '0;
            total_reg     <= '0;
            res_reg       <= '0;
            for (int k = 0; k <= MAX_N; k++)
            begin
                u_reg[k]  <= '0;
                v_reg[k]  <= '0;
                ms_reg[k] <= SLACK_INF;
                cm_reg[k] <= '0;
                bk_reg[k] <= '0;
            end
            for (int k = 0; k < MAX_N; k++)
            begin
                asg_reg[k] <= '0;
            end
        end
        else
        begin
            res_valid_reg <= (cmd.op == OP_OUT_EMIT);
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
            unique case (cmd.op)
                OP_NONE:
                begin
                end
                OP_SOLVE_INIT:
                begin
                    for (int k = 0; k <= MAX_N; k++)
                    begin
                        u_reg[k]  <= '0;
                        v_reg[k]  <= '0;
                        cm_reg[k] <= '0;
                    end
                    i_reg <= 5'd1;
                end
                OP_ROW_INIT:
                begin
                    for (int k = 0; k <= MAX_N; k++)
                    begin
                        ms_reg[k] <= SLACK_INF;
                    end
                    used_reg  <= '0;
                    cm_reg[0] <= i_reg;
                    j0_reg    <= '0;
                    guard_reg <= '0;
                end
                OP_STEP:
                begin
                    used_reg[j0_reg] <= 1'b1;
                    i0_reg    <= cm_reg[j0_reg];
                    ui0_reg   <= u_reg[cm_reg[j0_reg]];
                    delta_reg <= SLACK_INF;
                    j1_reg    <= '0;
                    j_reg     <= 5'd1;
                end
                OP_READ:
                begin
                end
                OP_COMPARE:
                begin
                    if (!used_reg[j_reg])
                    begin
                        ms_reg[j_reg] <= new_ms;
                        if (cur < ms_reg[j_reg])
                        begin
                            bk_reg[j_reg] <= j0_reg;
                        end
                        if (new_ms < delta_reg)
                        begin
                            delta_reg <= new_ms;
                            j1_reg    <= j_reg;
                        end
                    end
                    j_reg <= stat.scan_done ? 5'd0 : j_reg + 5'd1;
                end
                OP_UPDATE:
                begin
                    if (used_reg[j_reg])
                    begin
                        if (cm_reg[j_reg] <= 5'(MAX_N))
                        begin
                            u_reg[cm_reg[j_reg]] <= u_reg[cm_reg[j_reg]] + delta_reg;
                        end
                        v_reg[j_reg] <= v_reg[j_reg] - delta_reg;
                    end
                    else
                    begin
                        ms_reg[j_reg] <= ms_reg[j_reg] - delta_reg;
                    end
                    j_reg <= j_reg + 5'd1;
                    if (stat.scan_done)
                    begin
                        j0_reg    <= j1_reg;
                        guard_reg <= stat.step_again ? guard_reg + 5'd1 : 5'd0;
                    end
                end
                OP_AUGMENT:
                begin
                    cm_reg[j0_reg] <= cm_reg[jb];
                    j0_reg         <= jb;
                    guard_reg      <= guard_reg + 5'd1;
                    if (stat.aug_last)
                    begin
                        i_reg <= i_reg + 5'd1;
                        j_reg <= 5'd1;
                    end
                end
                OP_ASSIGN:
                begin
                    if ((cm_reg[j_reg] >= 5'd1) && (cm_reg[j_reg] <= n))
                    begin
                        asg_reg[p[3:0]] <= jm1[3:0];
                    end
                    j_reg <= j_reg + 5'd1;
                    if (stat.scan_done)
                    begin
                        r_reg     <= '0;
                        total_reg <= '0;
                    end
                end
                OP_OUT_READ:
                begin
                end
                OP_OUT_EMIT:
                begin
                    res_reg.result_row    <= r_reg;
                    res_reg.assigned_col  <= asg_reg[r_reg];
                    res_reg.pair_cost     <= cost;
                    res_reg.running_total <= total_sum;
                    res_reg.last_result   <= stat.out_done;
                    total_reg             <= total_sum;
                    r_reg                 <= r_reg + 4'd1;
                end
                default:
                begin
                end
            endcase
            if (cmd.op == OP_SOLVE_INIT)
            begin
                for (int k = 0; k < MAX_N; k++)
                begin
                    asg_reg[k] <= '0;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/min_cost_assignment_solver_core.sv =====
// Top level of the min-cost assignment solver (Hungarian algorithm).
// Loading accepts one entry transfer per cycle; busy stays low while entries stream in.
// After the last entry each augmenting step has a setup state, a cost memory read and compare
// per column, and an update pass over columns 0 to n; each row has one init state, its steps
// and its augment pass, and an assignment pass over the columns follows the last row.
// Results follow as n transfers, each strobed for one cycle.
// Reset is asynchronous, active low; matrix_size returns to 1, the cost memory is not cleared.
`default_nettype none
module min_cost_assignment_solver_core
    import mcas_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_data,
    input  wire logic       start,
    input  wire entry_t     entry,
    output logic            busy,
    output logic            result_valid,
    output result_t         result
);

    // The controller only issues commands; all storage and arithmetic lives in the datapath.
    cmd_t  cmd;
    stat_t stat;

    mcas_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_entry (entry.last_entry),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy)
    );

    // The datapath also keeps the matrix size register and the result register.
    mcas_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .entry        (entry),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/mcas_checker.sv =====
// Port-level checker for the min-cost assignment solver, bound to the top level.
`default_nettype none
module mcas_checker
    import mcas_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire entry_t  entry,
    input wire logic    busy,
    input wire logic    result_valid,
    input wire result_t result
);

    a_solve_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && entry.last_entry) |=> busy)
        else $error("solve did not start after last entry");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_result) |-> !busy)
        else $error("busy after final result");

    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_result) |-> ##2 result_valid)
        else $error("next result missing");

    a_running_total: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_result) |-> ##2
        (result.running_total == $past(result.running_total, 2)
            + TOTAL_W'(result.pair_cost)))
        else $error("running total mismatch");

endmodule

bind min_cost_assignment_solver_core mcas_checker u_mcas_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .entry        (entry),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
`default_nettype wire
